// ===== src/sorted_priority_queue_unit_macros.svh =====
// Assertion macros for the sorted priority queue unit.
// Expects clk and rst in the scope of each use.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/spq_pkg.sv =====
// Package for the sorted priority queue unit: entry and command types, codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int PrioW  = 8;
  localparam int ValueW = 16;
  localparam int CountW = 5;
  localparam int CapW   = 5;
  localparam int StatW  = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [StatW-1:0] ST_OK    = 2'd0;
  localparam logic [StatW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatW-1:0] ST_FULL  = 2'd2;

  localparam logic [CapW-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic [PrioW-1:0]  prio;
    logic [ValueW-1:0] value;
  } entry_t;

  typedef struct packed {
    logic   insert;
    logic   remove;
    entry_t new_entry;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== src/spq_if.sv =====
// Handshake channels of the sorted priority queue unit: input and result beats.
// Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface spq_in_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [spq_pkg::PrioW-1:0]  item_priority;
  logic [spq_pkg::ValueW-1:0] item_value;

  modport source (output valid, output opcode, output item_priority, output item_value,
                  input ready);
  modport sink   (input valid, input opcode, input item_priority, input item_value,
                  output ready);
endinterface

interface spq_out_if;
  logic                       valid;
  logic                       ready;
  logic [spq_pkg::PrioW-1:0]  out_priority;
  logic [spq_pkg::ValueW-1:0] out_value;
  logic [spq_pkg::StatW-1:0]  status;
  logic [spq_pkg::CountW-1:0] count_after;

  modport source (output valid, output out_priority, output out_value, output status,
                  output count_after, input ready);
  modport sink   (input valid, input out_priority, input out_value, input status,
                  input count_after, output ready);
endinterface

`default_nettype wire

// ===== src/spq_cell.sv =====
// One slot of the sorted chain: holds an entry, shifts back on insert, forward on remove.
// Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
  input  wire                      clk,
  input  wire spq_pkg::cell_cmd_t  cmd,
  input  wire                      occupied,
  input  wire spq_pkg::entry_t     left_entry,
  input  wire                      left_behind,
  input  wire spq_pkg::entry_t     right_entry,
  output spq_pkg::entry_t          entry,
  output logic                     behind
);

  // Behind the insert point: empty, or lower priority than the new entry.
  assign behind = !occupied || (entry.prio < cmd.new_entry.prio);

  always_ff @(posedge clk) begin
    if (cmd.insert && behind) begin
      entry <= left_behind ? left_entry : cmd.new_entry;
    end else if (cmd.remove) begin
      entry <= right_entry;
    end
  end

endmodule

`default_nettype wire

// ===== src/sorted_priority_queue_unit.sv =====
// Channel   | Dir | Beat payload
// in_ch     | in  | opcode, item_priority, item_value
// out_ch    | out | out_priority, out_value, status, count_after
// cfg       | in  | cfg_we, cfg_data (capacity)
// One item per cycle unless out_ch stalls: the cell chain inserts or removes in the
// cycle of acceptance; the result goes to an output register, shown the next cycle.
// in_ch.ready is low only while a result waits and out_ch.ready is low.
// rst is synchronous: queue empties, capacity returns to 16, no result pending.
// Depends on spq_pkg, spq_if, spq_cell and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_priority_queue_unit_macros.svh"

module sorted_priority_queue_unit #(
  parameter int DEPTH = 16
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       cfg_we,
  input  wire [spq_pkg::CapW-1:0]   cfg_data,
  spq_in_if.sink                    in_ch,
  spq_out_if.source                 out_ch
);

  logic [spq_pkg::CapW-1:0]   capacity;
  logic [spq_pkg::CountW-1:0] count;
  logic [spq_pkg::CountW-1:0] count_next;
  logic [spq_pkg::CapW-1:0]   usable;
  logic                       out_valid;
  logic                       in_acc;
  logic                       full;
  logic                       empty;
  logic [spq_pkg::StatW-1:0]  stat_next;
  spq_pkg::cell_cmd_t         cmd;
  logic [DEPTH-1:0]           occ;
  logic [DEPTH-1:0]           behind;
  logic [DEPTH-1:0]           left_b;
  spq_pkg::entry_t            ent    [DEPTH];
  spq_pkg::entry_t            left_e [DEPTH];
  spq_pkg::entry_t            right_e[DEPTH];

  assign in_ch.ready  = !out_valid || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= spq_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  always_comb begin
    if (capacity == '0) begin
      usable = spq_pkg::CapW'(1);
    end else if (int'(capacity) > DEPTH) begin
      usable = spq_pkg::CapW'(DEPTH);
    end else begin
      usable = capacity;
    end
  end

  assign full  = (count >= usable);
  assign empty = (count == '0);

  always_comb begin
    cmd.new_entry.prio  = in_ch.item_priority;
    cmd.new_entry.value = in_ch.item_value;
    cmd.insert = in_acc && (in_ch.opcode == spq_pkg::OP_INSERT) && !full;
    cmd.remove = in_acc && (in_ch.opcode == spq_pkg::OP_REMOVE) && !empty;
  end

  always_comb begin
    count_next = count;
    stat_next  = spq_pkg::ST_OK;
    if (in_ch.opcode == spq_pkg::OP_INSERT) begin
      if (full) begin
        stat_next = spq_pkg::ST_FULL;
      end else begin
        count_next = count + 1'b1;
      end
    end else begin
      if (empty) begin
        stat_next = spq_pkg::ST_EMPTY;
      end else begin
        count_next = count - 1'b1;
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      assign occ[g] = (int'(count) > g);
      if (g == 0) begin : g_head
        assign left_e[g] = cmd.new_entry;
        assign left_b[g] = 1'b0;
      end else begin : g_body
        assign left_e[g] = ent[g-1];
        assign left_b[g] = behind[g-1];
      end
      if (g == DEPTH - 1) begin : g_tail
        assign right_e[g] = ent[g];
      end else begin : g_mid
        assign right_e[g] = ent[g+1];
      end
      spq_cell u_cell (
        .clk         (clk),
        .cmd         (cmd),
        .occupied    (occ[g]),
        .left_entry  (left_e[g]),
        .left_behind (left_b[g]),
        .right_entry (right_e[g]),
        .entry       (ent[g]),
        .behind      (behind[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_ch.status      <= stat_next;
      out_ch.count_after <= count_next;
      if (cmd.remove) begin
        out_ch.out_priority <= ent[0].prio;
        out_ch.out_value    <= ent[0].value;
      end else begin
        out_ch.out_priority <= '0;
        out_ch.out_value    <= '0;
      end
    end
  end

  `SPQ_ASSERT_NOW(a_count_bound, 1'b1, int'(count) <= DEPTH, "fill level above depth")
  `SPQ_ASSERT_NEXT(a_count_hold, !in_acc, $stable(count), "fill level moved without a beat")
  `SPQ_ASSERT_NOW(a_head_sorted, count >= spq_pkg::CountW'(2), ent[0].prio >= ent[1].prio,
                  "head entry below its successor")
  `SPQ_ASSERT_NEXT(a_empty_flag, in_acc && cmd.remove == 1'b0 && in_ch.opcode == spq_pkg::OP_REMOVE,
                   out_ch.status == spq_pkg::ST_EMPTY, "remove on empty not flagged")

endmodule

`default_nettype wire
